// File: hdl/keypad_autorepeat_event_fifo_assert.svh
// ----------------------------------------------------------------------------
// Keypad autorepeat event FIFO - assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_AUTOREPEAT_EVENT_FIFO_ASSERT_SVH
`define KEYPAD_AUTOREPEAT_EVENT_FIFO_ASSERT_SVH

// same-cycle implication
`define KAR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KAR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/kar_pkg.sv
// ----------------------------------------------------------------------------
// kar_pkg
// Types and constants shared by the keypad autorepeat event FIFO.
// ----------------------------------------------------------------------------
package kar_pkg;

   localparam int KAR_FIFO_DEPTH = 16;
   localparam int PAD_W          = 16;
   localparam int HOLD_W         = 8;
   localparam int KIND_W         = 2;
   localparam int PHASE_W        = 2;
   localparam int COUNT_OUT_W    = 5;

   localparam logic [HOLD_W-1:0] HOLD_DELAY_RST = 8'h20;

   typedef enum logic [KIND_W-1:0] {
      KIND_POLL  = 2'd0,
      KIND_PUSH  = 2'd1,
      KIND_POP   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

   typedef struct packed {
      logic [PAD_W-1:0] held;
      logic [PAD_W-1:0] fresh;
      logic [PAD_W-1:0] rpt;
   } pad_words_type;

   // six current words: index 0 is pad one, index 1 is pad two
   typedef pad_words_type [1:0] snap_type;

   typedef struct packed {
      snap_type               words;
      logic [COUNT_OUT_W-1:0] queued;
      logic [COUNT_OUT_W-1:0] pop_answer;
      logic                   overflowed;
   } result_type;

   typedef struct packed {
      logic req_ready;
      logic pop_done;
   } fsm_out_type;

endpackage

// File: hdl/kar_req_if.sv
// ----------------------------------------------------------------------------
// kar_req_if
// Request channel: one poll, push, pop or clear transaction.
// ----------------------------------------------------------------------------
interface kar_req_if import kar_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [PAD_W-1:0]   pad1_buttons;
   logic [PAD_W-1:0]   pad2_buttons;
   logic [PHASE_W-1:0] frame_phase;

   modport source (output valid, output kind, output pad1_buttons,
                   output pad2_buttons, output frame_phase, input ready);
   modport sink   (input valid, input kind, input pad1_buttons,
                   input pad2_buttons, input frame_phase, output ready);

endinterface

// File: hdl/kar_rsp_if.sv
// ----------------------------------------------------------------------------
// kar_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface kar_rsp_if import kar_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [PAD_W-1:0]       held_one;
   logic [PAD_W-1:0]       held_two;
   logic [PAD_W-1:0]       fresh_one;
   logic [PAD_W-1:0]       fresh_two;
   logic [PAD_W-1:0]       repeat_one;
   logic [PAD_W-1:0]       repeat_two;
   logic [COUNT_OUT_W-1:0] queued;
   logic [COUNT_OUT_W-1:0] pop_answer;
   logic                   overflowed;

   modport source (output valid, output held_one, output held_two,
                   output fresh_one, output fresh_two, output repeat_one,
                   output repeat_two, output queued, output pop_answer,
                   output overflowed, input ready);
   modport sink   (input valid, input held_one, input held_two,
                   input fresh_one, input fresh_two, input repeat_one,
                   input repeat_two, input queued, input pop_answer,
                   input overflowed, output ready);

endinterface

// File: hdl/kar_csr_if.sv
// ----------------------------------------------------------------------------
// kar_csr_if
// Register write channel for hold_delay.
// ----------------------------------------------------------------------------
interface kar_csr_if import kar_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [HOLD_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// File: hdl/kar_poll_unit.sv
// ----------------------------------------------------------------------------
// kar_poll_unit
// Edge detect and typematic repeat for one pad.
// ----------------------------------------------------------------------------
module kar_poll_unit import kar_pkg::*; (
   input  logic [PAD_W-1:0]   held,
   input  logic [PAD_W-1:0]   prev,
   input  logic [HOLD_W-1:0]  hold_count,
   input  logic [HOLD_W-1:0]  hold_delay,
   input  logic [PHASE_W-1:0] frame_phase,
   output pad_words_type      words,
   output logic [HOLD_W-1:0]  hold_count_next
);

   logic [PAD_W-1:0]  fresh;
   logic [HOLD_W-1:0] cnt;

   always_comb begin
      fresh = held & ~prev;
      cnt   = (fresh != '0) ? '0 : hold_count;
      words.held  = held;
      words.fresh = fresh;
      if (cnt < hold_delay) begin
         hold_count_next = cnt + 1'b1;
         words.rpt       = fresh;
      end else begin
         hold_count_next = cnt;
         words.rpt       = (frame_phase == '0) ? held : fresh;
      end
   end

endmodule

// File: hdl/kar_snap_mem.sv
// ----------------------------------------------------------------------------
// kar_snap_mem
// Snapshot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kar_snap_mem import kar_pkg::*; #(
   parameter int DEPTH  = KAR_FIFO_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  snap_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output snap_type          rd_data
);

   snap_type snap_mem [DEPTH];
   snap_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         snap_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= snap_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/keypad_autorepeat_event_fifo.sv
// ----------------------------------------------------------------------------
// keypad_autorepeat_event_fifo
// Two-pad edge detector with typematic repeat and a snapshot FIFO.
// ----------------------------------------------------------------------------
// Results: poll, push, clear and pop-when-empty load the output register (or skid
//   stage) at the accept edge; a stored pop reads the memory, then loads in ST_POP.
// Throughput: 1 transaction per cycle with the skid stage free, none during ST_POP.
// Reset: synchronous, clears pointers, counters, words and flags, hold_delay = 32;
//   the snapshot memory is not cleared, the pointers guard it.
module keypad_autorepeat_event_fifo import kar_pkg::*; #(
   parameter int FIFO_DEPTH = KAR_FIFO_DEPTH
) (
   input logic       clock,
   input logic       reset,
   kar_req_if.sink   req_ch,
   kar_rsp_if.source rsp_ch,
   kar_csr_if.sink   csr_ch
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // control state
   state_type         state_ff, state_in;
   logic [HOLD_W-1:0] hold_delay_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              full_ff, full_in;

   // per-pad poll state
   logic [1:0][PAD_W-1:0]  prev_ff, prev_in;
   logic [1:0][HOLD_W-1:0] hold_cnt_ff, hold_cnt_in;
   snap_type               cur_ff, cur_in;

   // output register and skid stage
   result_type rsp_ff, skid_ff, res_in;
   logic       rsp_valid_ff, skid_valid_ff;

   fsm_out_type fsm_out;
   kind_type    kind;
   logic        accept;
   logic        produce;
   logic        fifo_empty;
   logic        fifo_full;
   logic        mem_wr_en;
   logic        mem_rd_en;
   snap_type    mem_rd_data;
   snap_type    poll_words;
   logic [1:0][HOLD_W-1:0] poll_cnt;
   logic [CNT_W-1:0]       answer;
   logic [CNT_W+COUNT_OUT_W-1:0] queued_ext;
   logic [CNT_W+COUNT_OUT_W-1:0] answer_ext;

   assign kind       = kind_type'(req_ch.kind);
   assign accept     = req_ch.valid & fsm_out.req_ready;
   assign fifo_empty = (count_ff == '0);
   assign fifo_full  = (count_ff == CNT_FULL);

   // ---------------------------------------------------------------------
   // Poll units, one per pad
   // ---------------------------------------------------------------------
   kar_poll_unit u_poll_one (
      .held            (req_ch.pad1_buttons),
      .prev            (prev_ff[0]),
      .hold_count      (hold_cnt_ff[0]),
      .hold_delay      (hold_delay_ff),
      .frame_phase     (req_ch.frame_phase),
      .words           (poll_words[0]),
      .hold_count_next (poll_cnt[0])
   );

   kar_poll_unit u_poll_two (
      .held            (req_ch.pad2_buttons),
      .prev            (prev_ff[1]),
      .hold_count      (hold_cnt_ff[1]),
      .hold_delay      (hold_delay_ff),
      .frame_phase     (req_ch.frame_phase),
      .words           (poll_words[1]),
      .hold_count_next (poll_cnt[1])
   );

   // ---------------------------------------------------------------------
   // Snapshot memory. Push writes the current words at the accept edge;
   // pop reads at the accept edge and loads the words into cur_ff in the cycle after.
   // One request in flight at a time, so no read/write overlap on an entry.
   // ---------------------------------------------------------------------
   assign mem_wr_en = accept && (kind == KIND_PUSH) && !fifo_full;
   assign mem_rd_en = accept && (kind == KIND_POP) && !fifo_empty;

   kar_snap_mem #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_snap_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (cur_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (mem_rd_en) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs. New request only in ST_IDLE with the skid stage free,
   // so a result always has a place to land.
   always_comb begin
      fsm_out = '0;
      unique case (state_ff)
         ST_IDLE: begin
            fsm_out.req_ready = !skid_valid_ff;
         end
         ST_POP: begin
            fsm_out.pop_done = 1'b1;
         end
         default: begin
            fsm_out = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      full_in     = full_ff;
      prev_in     = prev_ff;
      hold_cnt_in = hold_cnt_ff;
      cur_in      = cur_ff;
      answer      = '0;
      produce     = 1'b0;

      if (accept) begin
         unique case (kind)
            KIND_POLL: begin
               prev_in[0]  = req_ch.pad1_buttons;
               prev_in[1]  = req_ch.pad2_buttons;
               hold_cnt_in = poll_cnt;
               cur_in      = poll_words;
               produce     = 1'b1;
            end
            KIND_PUSH: begin
               if (!fifo_full) begin
                  wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
               produce = 1'b1;
            end
            KIND_POP: begin
               // stored snapshot: result comes from the memory next cycle
               if (!fifo_empty) begin
                  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
               end else begin
                  produce = 1'b1;
               end
            end
            KIND_CLEAR: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
               count_in  = '0;
               full_in   = 1'b0;
               cur_in    = '0;
               produce   = 1'b1;
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end

      if (fsm_out.pop_done) begin
         cur_in   = mem_rd_data;
         answer   = count_ff;
         count_in = count_ff - 1'b1;
         produce  = 1'b1;
      end
   end

   // result fields carry only the low bits of the counts
   assign queued_ext = {{COUNT_OUT_W{1'b0}}, count_in};
   assign answer_ext = {{COUNT_OUT_W{1'b0}}, answer};

   always_comb begin
      res_in.words      = cur_in;
      res_in.queued     = queued_ext[COUNT_OUT_W-1:0];
      res_in.pop_answer = answer_ext[COUNT_OUT_W-1:0];
      res_in.overflowed = full_in;
   end

   // ---------------------------------------------------------------------
   // State registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_delay_ff <= HOLD_DELAY_RST;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         full_ff       <= 1'b0;
         prev_ff       <= '0;
         hold_cnt_ff   <= '0;
         cur_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         full_ff     <= full_in;
         prev_ff     <= prev_in;
         hold_cnt_ff <= hold_cnt_in;
         cur_ff      <= cur_in;
         if (csr_ch.valid) begin
            hold_delay_ff <= csr_ch.data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register plus skid stage: a result lands in the skid stage only
   // when the output register is stalled.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (produce) begin
            if (rsp_valid_ff && !rsp_ch.ready) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         if (rsp_valid_ff && !rsp_ch.ready) begin
            skid_ff <= res_in;
         end else begin
            rsp_ff <= res_in;
         end
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_ff <= skid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_ch.ready      = fsm_out.req_ready;
   assign csr_ch.ready      = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.held_one   = rsp_ff.words[0].held;
   assign rsp_ch.held_two   = rsp_ff.words[1].held;
   assign rsp_ch.fresh_one  = rsp_ff.words[0].fresh;
   assign rsp_ch.fresh_two  = rsp_ff.words[1].fresh;
   assign rsp_ch.repeat_one = rsp_ff.words[0].rpt;
   assign rsp_ch.repeat_two = rsp_ff.words[1].rpt;
   assign rsp_ch.queued     = rsp_ff.queued;
   assign rsp_ch.pop_answer = rsp_ff.pop_answer;
   assign rsp_ch.overflowed = rsp_ff.overflowed;

endmodule

// File: hdl/kar_checker.sv
// ----------------------------------------------------------------------------
// kar_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_autorepeat_event_fifo_assert.svh"

module kar_checker import kar_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [PAD_W-1:0]       held_one,
   input logic [PAD_W-1:0]       held_two,
   input logic [PAD_W-1:0]       fresh_one,
   input logic [PAD_W-1:0]       fresh_two,
   input logic [PAD_W-1:0]       repeat_one,
   input logic [PAD_W-1:0]       repeat_two,
   input logic [COUNT_OUT_W-1:0] queued,
   input logic [COUNT_OUT_W-1:0] pop_answer
);

   logic extra_one;
   logic extra_two;

   // fresh and repeat bits are always a subset of the held word
   assign extra_one = ((fresh_one | repeat_one) & ~held_one) != '0;
   assign extra_two = ((fresh_two | repeat_two) & ~held_two) != '0;

   `KAR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `KAR_ASSERT_NXT(a_rst_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")
   `KAR_ASSERT_IMP(a_subset, clock, reset, rsp_valid, !extra_one && !extra_two, "bits not held")
   `KAR_ASSERT_IMP(a_pop_cnt, clock, reset, rsp_valid && (pop_answer != '0),
      queued == (pop_answer - 1'b1), "pop count mismatch")

endmodule

bind keypad_autorepeat_event_fifo kar_checker u_kar_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .held_one   (rsp_ch.held_one),
   .held_two   (rsp_ch.held_two),
   .fresh_one  (rsp_ch.fresh_one),
   .fresh_two  (rsp_ch.fresh_two),
   .repeat_one (rsp_ch.repeat_one),
   .repeat_two (rsp_ch.repeat_two),
   .queued     (rsp_ch.queued),
   .pop_answer (rsp_ch.pop_answer)
);

// File: tb/tb_keypad_autorepeat_event_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_autorepeat_event_fifo
// Self-checking bench for the two-pad edge detector with typematic repeat and
// snapshot FIFO. A directed table runs first, then random poll/push/pop/clear
// traffic under several hold_delay settings. Every response is checked field by
// field against a cycle-free model of pads, hold counters and FIFO, or a pinned result.
// ----------------------------------------------------------------------------
module tb_keypad_autorepeat_event_fifo;
   import kar_pkg::*;

   localparam int STALL_PCT  = 10;         // idle odds per cycle, both sides
   localparam int TIMEOUT_NS = 2_000_000;  // far beyond the slowest legal run
   localparam result_type NO_REPORT = '0;  // reset state: all words and counts zero

   // one row of the directed table: a burst of identical requests or a
   // hold_delay write
   typedef enum logic {STEP_ITEM, STEP_DELAY} step_op_type;

   typedef struct {
      step_op_type        op;
      kind_type           kind;
      logic [PAD_W-1:0]   pad1;
      logic [PAD_W-1:0]   pad2;
      logic [PHASE_W-1:0] phase;
      logic [HOLD_W-1:0]  setting;
      int                 reps;
      bit                 pinned;   // use the typed-in result instead of the model
      result_type         want;
   } step_type;

   logic clock;
   logic reset;

   kar_req_if req_ch ();
   kar_rsp_if rsp_ch ();
   kar_csr_if csr_ch ();

   keypad_autorepeat_event_fifo #(.FIFO_DEPTH(KAR_FIFO_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ------------------------------------------------------------------------
   // Model state: mirrors what the block must hold between transactions
   // ------------------------------------------------------------------------
   logic [HOLD_W-1:0] delay_shadow;
   logic [PAD_W-1:0]  last_polled [2];
   logic [HOLD_W-1:0] hold_ticks [2];
   snap_type          live_words;
   snap_type          saved_words [KAR_FIFO_DEPTH];
   int                put_idx;
   int                take_idx;
   int                depth_used;
   logic              overflow_seen;

   result_type        pending_reports [$];  // oldest first
   step_type          directed_steps [$];
   int                mismatch_count;
   bit                steady;               // no idling on either side while set

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of one transaction; updates the model state and returns the
   // response the block must give for it
   // ------------------------------------------------------------------------
   function automatic result_type next_report(input kind_type kind,
                                              input logic [PAD_W-1:0] pad1,
                                              input logic [PAD_W-1:0] pad2,
                                              input logic [PHASE_W-1:0] phase);
      result_type             r;
      logic [PAD_W-1:0]       held [2];
      logic [PAD_W-1:0]       fresh;
      logic [COUNT_OUT_W-1:0] answer;
      held[0] = pad1;
      held[1] = pad2;
      answer  = '0;
      case (kind)
         KIND_POLL: begin
            for (int p = 0; p < 2; p++) begin
               fresh          = held[p] & ~last_polled[p];
               last_polled[p] = held[p];
               // any new press restarts the typematic delay
               if (fresh != '0) hold_ticks[p] = '0;
               live_words[p].held  = held[p];
               live_words[p].fresh = fresh;
               if (hold_ticks[p] < delay_shadow) begin
                  hold_ticks[p]     = hold_ticks[p] + 1'b1;
                  live_words[p].rpt = fresh;
               end else if (phase != '0) begin
                  live_words[p].rpt = fresh;
               end else begin
                  // repeat phase, frame 0: whole held word repeats
                  live_words[p].rpt = held[p];
               end
            end
         end
         KIND_PUSH: begin
            if (depth_used < KAR_FIFO_DEPTH) begin
               saved_words[put_idx] = live_words;
               put_idx    = (put_idx + 1) % KAR_FIFO_DEPTH;
               depth_used = depth_used + 1;
            end else begin
               overflow_seen = 1'b1;   // sticky, nothing stored
            end
         end
         KIND_POP: begin
            if (depth_used != 0) begin
               live_words = saved_words[take_idx];
               take_idx   = (take_idx + 1) % KAR_FIFO_DEPTH;
               answer     = COUNT_OUT_W'(depth_used);
               depth_used = depth_used - 1;
            end
         end
         KIND_CLEAR: begin
            // prev words and hold counters survive a clear
            depth_used    = 0;
            put_idx       = 0;
            take_idx      = 0;
            overflow_seen = 1'b0;
            live_words    = '0;
         end
      endcase
      r.words      = live_words;
      r.queued     = COUNT_OUT_W'(depth_used);
      r.pop_answer = answer;
      r.overflowed = overflow_seen;
      return r;
   endfunction

   // typed-in response for directed rows
   function automatic result_type report_of(input logic [PAD_W-1:0] h1, h2, f1, f2, r1, r2,
                                            input logic [COUNT_OUT_W-1:0] queued, answer,
                                            input logic ovf);
      result_type r;
      r.words[0].held  = h1;
      r.words[1].held  = h2;
      r.words[0].fresh = f1;
      r.words[1].fresh = f2;
      r.words[0].rpt   = r1;
      r.words[1].rpt   = r2;
      r.queued         = queued;
      r.pop_answer     = answer;
      r.overflowed     = ovf;
      return r;
   endfunction

   function automatic void add_item(input kind_type kind,
                                    input logic [PAD_W-1:0] pad1, pad2,
                                    input logic [PHASE_W-1:0] phase,
                                    input int reps, input bit pinned,
                                    input result_type want);
      step_type s;
      s.op      = STEP_ITEM;
      s.kind    = kind;
      s.pad1    = pad1;
      s.pad2    = pad2;
      s.phase   = phase;
      s.setting = '0;
      s.reps    = reps;
      s.pinned  = pinned;
      s.want    = want;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_delay(input logic [HOLD_W-1:0] value);
      step_type s;
      s.op      = STEP_DELAY;
      s.kind    = KIND_POLL;
      s.pad1    = '0;
      s.pad2    = '0;
      s.phase   = '0;
      s.setting = value;
      s.reps    = 0;
      s.pinned  = 1'b0;
      s.want    = NO_REPORT;
      directed_steps.push_back(s);
   endfunction

   function automatic void compare_field(input string name,
                                         input logic [PAD_W-1:0] expected,
                                         input logic [PAD_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %h, got %h", name, expected, actual);
         mismatch_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. Called at a falling edge; returns at the falling edge
   // after the transaction was accepted. Valid gets one update per step.
   // ------------------------------------------------------------------------
   task automatic send_request(input kind_type kind,
                               input logic [PAD_W-1:0] pad1, pad2,
                               input logic [PHASE_W-1:0] phase,
                               input bit pinned, input result_type want);
      result_type predicted;
      while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.pad1_buttons <= pad1;
      req_ch.pad2_buttons <= pad2;
      req_ch.frame_phase  <= phase;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = next_report(kind, pad1, pad2, phase);
      pending_reports.push_back(pinned ? want : predicted);
      @(negedge clock);
   endtask

   // hold off requests until every outstanding response has come back;
   // always waits on the falling edge before checking, so valid is not touched twice in a step
   task automatic wait_for_quiet();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_reports.size() != 0);
   endtask

   // hold_delay is only written with the block drained
   task automatic write_hold_delay(input logic [HOLD_W-1:0] value);
      wait_for_quiet();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      delay_shadow = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random backpressure unless steady; checks every accepted transaction
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
   end

   always @(posedge clock) begin : watch_responses
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reports.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("held_one",   want.words[0].held,  rsp_ch.held_one);
            compare_field("held_two",   want.words[1].held,  rsp_ch.held_two);
            compare_field("fresh_one",  want.words[0].fresh, rsp_ch.fresh_one);
            compare_field("fresh_two",  want.words[1].fresh, rsp_ch.fresh_two);
            compare_field("repeat_one", want.words[0].rpt,   rsp_ch.repeat_one);
            compare_field("repeat_two", want.words[1].rpt,   rsp_ch.repeat_two);
            compare_field("queued",     PAD_W'(want.queued),
                          PAD_W'(rsp_ch.queued));
            compare_field("pop_answer", PAD_W'(want.pop_answer),
                          PAD_W'(rsp_ch.pop_answer));
            compare_field("overflowed", PAD_W'(want.overflowed),
                          PAD_W'(rsp_ch.overflowed));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [PAD_W-1:0]  keys_one;
      logic [PAD_W-1:0]  keys_two;
      logic [HOLD_W-1:0] phase_delays [5];
      kind_type          kind;
      int                roll;
      int                push_bias;

      reset               = 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.kind         <= KIND_POLL;
      req_ch.pad1_buttons <= '0;
      req_ch.pad2_buttons <= '0;
      req_ch.frame_phase  <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.data         <= '0;

      delay_shadow   = HOLD_DELAY_RST;
      last_polled    = '{default: '0};
      hold_ticks     = '{default: '0};
      live_words     = '0;
      put_idx        = 0;
      take_idx       = 0;
      depth_used     = 0;
      overflow_seen  = 1'b0;
      mismatch_count = 0;
      steady         = 1'b0;
      keys_one       = '0;
      keys_two       = '0;

      // --- directed table ---------------------------------------------------
      // pop on an empty FIFO right after reset: all zero
      add_item(KIND_POP, 16'hFFFF, 16'hFFFF, 2'd3, 1, 1'b1, NO_REPORT);
      // every button pressed at once: all fresh, still inside the delay
      add_item(KIND_POLL, 16'hFFFF, 16'hFFFF, 2'd0, 1, 1'b1,
               report_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         5'd0, 5'd0, 1'b0));
      // held again: no fresh bits, delay not yet over so no repeat
      add_item(KIND_POLL, 16'hFFFF, 16'hFFFF, 2'd0, 1, 1'b1,
               report_of(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                         5'd0, 5'd0, 1'b0));
      add_item(KIND_POLL, 16'h0000, 16'h0000, 2'd1, 1, 1'b0, NO_REPORT);
      add_item(KIND_POLL, 16'h8001, 16'h0001, 2'd2, 1, 1'b0, NO_REPORT);
      add_item(KIND_PUSH, 16'h0000, 16'h0000, 2'd0, 1, 1'b0, NO_REPORT);
      add_item(KIND_POLL, 16'h7FFE, 16'hFFFE, 2'd3, 1, 1'b0, NO_REPORT);
      // fill the FIFO, last push finds it full and sets the sticky flag
      add_item(KIND_PUSH, 16'h1234, 16'hABCD, 2'd1, 16, 1'b0, NO_REPORT);
      add_item(KIND_POP,  16'h0000, 16'h0000, 2'd0, 3, 1'b0, NO_REPORT);
      // pushes continue from the wrapped write pointer and fill the store again
      add_item(KIND_PUSH, 16'h0000, 16'h0000, 2'd0, 3, 1'b0, NO_REPORT);
      add_item(KIND_POP,  16'h0000, 16'h0000, 2'd0, 2, 1'b0, NO_REPORT);
      // clear with a nearly full FIFO and the overflow flag set
      add_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 2'd3, 1, 1'b1, NO_REPORT);
      add_item(KIND_POLL, 16'hA5A5, 16'h5A5A, 2'd0, 1, 1'b0, NO_REPORT);
      add_item(KIND_PUSH, 16'h0000, 16'h0000, 2'd0, 1, 1'b0, NO_REPORT);
      add_item(KIND_CLEAR, 16'h0000, 16'h0000, 2'd0, 1, 1'b0, NO_REPORT);
      add_item(KIND_POP,  16'h0000, 16'h0000, 2'd0, 1, 1'b1, NO_REPORT);
      // zero hold delay: repeat phase right away
      add_delay(8'd0);
      add_item(KIND_POLL, 16'h0F0F, 16'hF0F0, 2'd0, 1, 1'b0, NO_REPORT);
      add_item(KIND_POLL, 16'h0F0F, 16'hF0F0, 2'd1, 1, 1'b0, NO_REPORT);
      add_delay(8'd255);
      add_item(KIND_POLL, 16'hFFFF, 16'h0000, 2'd2, 1, 1'b0, NO_REPORT);
      add_item(KIND_POLL, 16'hFFFF, 16'h0000, 2'd0, 1, 1'b0, NO_REPORT);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].op == STEP_DELAY) begin
            write_hold_delay(directed_steps[i].setting);
         end else begin
            repeat (directed_steps[i].reps)
               send_request(directed_steps[i].kind, directed_steps[i].pad1,
                            directed_steps[i].pad2, directed_steps[i].phase,
                            directed_steps[i].pinned, directed_steps[i].want);
         end
      end

      // --- random traffic, one hold_delay setting per stretch ---------------
      // Buttons mostly change a bit at a time so presses get held long enough
      // to reach the repeat phase; now and then a whole new random word.
      phase_delays = '{8'd0, 8'd3, 8'd255, 8'd1, HOLD_W'($urandom_range(2, 40))};
      foreach (phase_delays[ph]) begin
         write_hold_delay(phase_delays[ph]);
         steady    = (ph == 1);                  // one stretch with no idling at all
         push_bias = (ph % 2 == 1) ? 25 : 10;    // alternate between filling and draining
         for (int n = 0; n < 100; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)                  kind = KIND_POLL;
            else if (roll < 55 + push_bias) kind = KIND_PUSH;
            else if (roll < 95)             kind = KIND_POP;
            else                            kind = KIND_CLEAR;
            if (kind == KIND_POLL) begin
               roll = $urandom_range(0, 99);
               if (roll >= 85) begin
                  keys_one = PAD_W'($urandom);
                  keys_two = PAD_W'($urandom);
               end else if (roll < 70) begin
                  keys_one ^= PAD_W'(1) << $urandom_range(0, PAD_W - 1);
                  keys_two ^= PAD_W'(1) << $urandom_range(0, PAD_W - 1);
               end
            end
            // now and then let everything drain before the next request
            if ($urandom_range(0, 99) < 2) wait_for_quiet();
            send_request(kind,
                         (kind == KIND_POLL) ? keys_one : PAD_W'($urandom),
                         (kind == KIND_POLL) ? keys_two : PAD_W'($urandom),
                         $urandom_range(0, 1) ? 2'd0 : PHASE_W'($urandom_range(1, 3)),
                         1'b0, NO_REPORT);
         end
      end
      steady = 1'b0;

      // drain, then let any stray response show up before the verdict
      wait_for_quiet();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/kar_pkg.sv
hdl/kar_req_if.sv
hdl/kar_rsp_if.sv
hdl/kar_csr_if.sv
hdl/kar_poll_unit.sv
hdl/kar_snap_mem.sv
hdl/keypad_autorepeat_event_fifo.sv
hdl/kar_checker.sv
tb/tb_keypad_autorepeat_event_fifo.sv
